[rtl/sstk_pkg.sv]
// shared constants and codes for the scope stack region table
`default_nettype none

package sstk_pkg;

    // default sizes
    localparam int REGION_COUNT_DEF = 64;
    localparam int STACK_DEPTH_DEF  = 16;

    // port field widths
    localparam int CMD_W    = 3;
    localparam int REGION_W = 6;
    localparam int AMOUNT_W = 12;
    localparam int VALUE_W  = 17;
    localparam int STATUS_W = 3;
    localparam int TOP_W    = 7;
    localparam int DEPTH_W  = 5;

    // frame size width and its ceiling
    localparam int SIZE_W = 16;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LEVEL  = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SIZE   = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CURRENT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STACK       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;

    // value reported when there is none
    localparam logic [VALUE_W-1:0] VALUE_NONE = '1;
    localparam logic [TOP_W-1:0]   TOP_NONE   = '1;

endpackage

`default_nettype wire

[rtl/sstk_ram.sv]
// single port synchronous ram with registered read data
`default_nettype none

module sstk_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[rtl/scope_stack_region_table_core.sv]
// scope stack and region table engine: command sequencer over two rams
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid in_ready cmd region amount | to core
//  out     | out_valid out_ready value status top_region stack_depth | from core
//
// one word at a time: accept, execute, deliver. append, next, push and pop
// without a stack read go from execute straight to deliver; pop to a non-empty
// stack, add size, read level and read size first pass a ram read state.
// search walks the stack ram from the top one entry a cycle until a hit or
// the bottom entry is compared.
// reset clears the registers only; the rams are not cleared and need no clearing pass.
// a new word is accepted while a finished result still waits at the output.
`default_nettype none

module scope_stack_region_table_core #(
    parameter int REGION_COUNT = sstk_pkg::REGION_COUNT_DEF,
    parameter int STACK_DEPTH  = sstk_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sstk_pkg::CMD_W-1:0]    cmd,
    input  wire logic [sstk_pkg::REGION_W-1:0] region,
    input  wire logic [sstk_pkg::AMOUNT_W-1:0] amount,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [sstk_pkg::VALUE_W-1:0] value,
    output logic      [sstk_pkg::STATUS_W-1:0] status,
    output logic signed [sstk_pkg::TOP_W-1:0]  top_region,
    output logic      [sstk_pkg::DEPTH_W-1:0]  stack_depth
);

    import sstk_pkg::*;

    // derived widths
    localparam int RW   = $clog2(REGION_COUNT);
    localparam int RCW  = $clog2(REGION_COUNT + 1);
    localparam int SW   = $clog2(STACK_DEPTH);
    localparam int SCW  = $clog2(STACK_DEPTH + 1);
    localparam int TW   = SIZE_W + SCW;
    localparam int CMPW = (RCW > REGION_W) ? RCW : REGION_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TBL_USE,
        S_POP_USE,
        S_SRCH,
        S_DONE
    } state_t;

    state_t state_reg;

    // latched word
    logic [CMD_W-1:0]    cmd_reg;
    logic [REGION_W-1:0] region_reg;
    logic [AMOUNT_W-1:0] amount_reg;

    // bookkeeping
    logic [SCW-1:0] count_reg;
    logic           cur_none_reg;
    logic [RCW-1:0] cur_reg;
    logic [RCW-1:0] used_reg;
    logic           top_none_reg;
    logic [RW-1:0]  top_reg;

    // search walk
    logic [SW-1:0] idx_reg;
    logic [SW-1:0] dist_reg;

    // pending result
    logic [VALUE_W-1:0]  res_value_reg;
    logic [STATUS_W-1:0] res_status_reg;

    // output register
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [TOP_W-1:0]    out_top_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;

    // ram ports
    logic          stk_we;
    logic [SW-1:0] stk_addr;
    logic [RW-1:0] stk_wdata;
    logic [RW-1:0] stk_rdata;
    logic          tbl_we;
    logic [RW-1:0] tbl_addr;
    logic [TW-1:0] tbl_wdata;
    logic [TW-1:0] tbl_rdata;

    // derived conditions
    logic              cur_valid;
    logic              stack_full;
    logic              stack_empty;
    logic              table_full;
    logic              level_hit;
    logic              srch_hit;
    logic [SIZE_W-1:0] new_size;
    logic [SIZE_W:0]   size_sum;
    logic [SIZE_W-1:0] size_sat;
    logic [SIZE_W-1:0] rd_size;
    logic [SCW-1:0]    rd_level;
    logic              out_free;

    sstk_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (RW)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    sstk_ram #(
        .DEPTH (REGION_COUNT),
        .WIDTH (TW)
    ) u_table_ram (
        .clk   (clk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    // conditions on the current state
    assign cur_valid   = !cur_none_reg && (cur_reg < used_reg);
    assign stack_full  = (count_reg == SCW'(STACK_DEPTH));
    assign stack_empty = (count_reg == '0);
    assign table_full  = (used_reg == RCW'(REGION_COUNT));
    assign level_hit   = (CMPW'(region_reg) < CMPW'(used_reg));
    assign srch_hit    = (CMPW'(stk_rdata) == CMPW'(region_reg));
    assign new_size    = (used_reg == '0) ? '0 : SIZE_W'(count_reg) + SIZE_W'(1);
    assign rd_size     = tbl_rdata[TW-1:SCW];
    assign rd_level    = tbl_rdata[SCW-1:0];
    assign size_sum    = {1'b0, rd_size} + (SIZE_W + 1)'(amount_reg);
    assign size_sat    = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
    assign out_free    = !out_valid_reg || out_ready;

    // ram address and write selection
    always_comb
    begin
        stk_we    = 1'b0;
        stk_addr  = idx_reg - SW'(1);
        stk_wdata = cur_reg[RW-1:0];
        tbl_we    = 1'b0;
        tbl_addr  = cur_reg[RW-1:0];
        tbl_wdata = {size_sat, rd_level};
        case (state_reg)
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_APPEND:
                    begin
                        tbl_we    = !table_full;
                        tbl_addr  = used_reg[RW-1:0];
                        tbl_wdata = {new_size, count_reg};
                    end
                    CMD_PUSH:
                    begin
                        stk_we   = cur_valid && !stack_full;
                        stk_addr = count_reg[SW-1:0];
                    end
                    CMD_POP:
                    begin
                        stk_addr = SW'(count_reg - SCW'(2));
                    end
                    CMD_SEARCH:
                    begin
                        stk_addr = SW'(count_reg - SCW'(1));
                    end
                    CMD_LEVEL:
                    begin
                        tbl_addr = RW'(region_reg);
                    end
                    default:
                    begin
                        tbl_addr = cur_reg[RW-1:0];
                    end
                endcase
            end
            S_TBL_USE:
            begin
                tbl_we = (cmd_reg == CMD_ADD);
            end
            default:
            begin
                stk_we = 1'b0;
            end
        endcase
    end

    // sequencer, bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            region_reg     <= '0;
            amount_reg     <= '0;
            count_reg      <= '0;
            cur_none_reg   <= 1'b1;
            cur_reg        <= '0;
            used_reg       <= '0;
            top_none_reg   <= 1'b1;
            top_reg        <= '0;
            idx_reg        <= '0;
            dist_reg       <= '0;
            res_value_reg  <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
            out_top_reg    <= '0;
            out_depth_reg  <= '0;
        end
        else
        begin
            // output word taken
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg    <= cmd;
                        region_reg <= region;
                        amount_reg <= amount;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_value_reg  <= VALUE_NONE;
                    res_status_reg <= ST_OK;
                    state_reg      <= S_DONE;
                    case (cmd_reg)
                        CMD_APPEND:
                        begin
                            if (table_full)
                            begin
                                res_status_reg <= ST_TABLE_FULL;
                            end
                            else
                            begin
                                used_reg <= used_reg + RCW'(1);
                            end
                        end
                        CMD_NEXT:
                        begin
                            if (cur_none_reg)
                            begin
                                cur_none_reg <= 1'b0;
                                cur_reg      <= '0;
                            end
                            else if (cur_reg < RCW'(REGION_COUNT))
                            begin
                                cur_reg <= cur_reg + RCW'(1);
                            end
                        end
                        CMD_PUSH:
                        begin
                            if (!cur_valid)
                            begin
                                res_status_reg <= ST_BAD_CURRENT;
                            end
                            else if (stack_full)
                            begin
                                res_status_reg <= ST_STACK;
                            end
                            else
                            begin
                                count_reg    <= count_reg + SCW'(1);
                                top_none_reg <= 1'b0;
                                top_reg      <= cur_reg[RW-1:0];
                            end
                        end
                        CMD_POP:
                        begin
                            if (stack_empty)
                            begin
                                res_status_reg <= ST_STACK;
                            end
                            else
                            begin
                                count_reg <= count_reg - SCW'(1);
                                if (count_reg == SCW'(1))
                                begin
                                    top_none_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_POP_USE;
                                end
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (stack_empty)
                            begin
                                res_status_reg <= ST_NOT_FOUND;
                            end
                            else
                            begin
                                idx_reg   <= SW'(count_reg - SCW'(1));
                                dist_reg  <= '0;
                                state_reg <= S_SRCH;
                            end
                        end
                        CMD_LEVEL:
                        begin
                            if (level_hit)
                            begin
                                state_reg <= S_TBL_USE;
                            end
                            else
                            begin
                                res_status_reg <= ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            // add size and read size need a valid current region
                            if (cur_valid)
                            begin
                                state_reg <= S_TBL_USE;
                            end
                            else
                            begin
                                res_status_reg <= ST_BAD_CURRENT;
                            end
                        end
                    endcase
                end
                S_TBL_USE:
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            res_value_reg <= {1'b0, size_sat};
                        end
                        CMD_LEVEL:
                        begin
                            res_value_reg <= VALUE_W'(rd_level);
                        end
                        default:
                        begin
                            res_value_reg <= {1'b0, rd_size};
                        end
                    endcase
                    state_reg <= S_DONE;
                end
                S_POP_USE:
                begin
                    top_reg   <= stk_rdata;
                    state_reg <= S_DONE;
                end
                S_SRCH:
                begin
                    // compare the entry read last cycle, next read already issued
                    if (srch_hit)
                    begin
                        res_value_reg <= VALUE_W'(dist_reg);
                        state_reg     <= S_DONE;
                    end
                    else if (idx_reg == '0)
                    begin
                        res_status_reg <= ST_NOT_FOUND;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        idx_reg  <= idx_reg - SW'(1);
                        dist_reg <= dist_reg + SW'(1);
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= res_value_reg;
                        out_status_reg <= res_status_reg;
                        out_top_reg    <= top_none_reg ? TOP_NONE : TOP_W'(top_reg);
                        out_depth_reg  <= DEPTH_W'(count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign value       = out_value_reg;
    assign status      = out_status_reg;
    assign top_region  = out_top_reg;
    assign stack_depth = out_depth_reg;

endmodule

`default_nettype wire
